### rtl/ssb_pkg.sv
`timescale 1ns / 1ps

package ssb_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_SPRITE_W = 3'd0;
  localparam logic [2:0] REG_SPRITE_H = 3'd1;
  localparam logic [2:0] REG_TILE_W   = 3'd2;
  localparam logic [2:0] REG_TILE_H   = 3'd3;
  localparam logic [2:0] REG_SCREEN_W = 3'd4;
  localparam logic [2:0] REG_SCREEN_H = 3'd5;

  // reset values of the registers
  localparam logic [6:0]  RST_SPRITE_W = 7'd32;
  localparam logic [6:0]  RST_SPRITE_H = 7'd32;
  localparam logic [6:0]  RST_TILE_W   = 7'd32;
  localparam logic [6:0]  RST_TILE_H   = 7'd32;
  localparam logic [12:0] RST_SCREEN_W = 13'd640;
  localparam logic [12:0] RST_SCREEN_H = 13'd480;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  // bounce turns down above this offset and up below one
  localparam logic [3:0] BOUNCE_TOP  = 4'd9;
  localparam logic [3:0] BOUNCE_PEAK = 4'd10;

  localparam logic [12:0] SCREEN_MAX = 13'd4096;

  // divider: 13-bit dividend, one quotient bit per step
  localparam int          DIV_W     = 13;
  localparam logic [3:0]  DIV_STEPS = 4'd13;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV_Y,
    S_DIV_X,
    S_INDEX,
    S_READ,
    S_CHECK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load_wr;
    logic latch;
    logic div_start;
    logic div_sel_x;
    logic qy_save;
    logic idx_en;
    logic rd_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic div_done;
    logic src_ok;
    logic keep;
    logic out_free;
  } stat_t;

endpackage

### rtl/ssb_div.sv
`timescale 1ns / 1ps

module ssb_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ssb_pkg::DIV_W-1:0] dividend,
  input  logic [6:0]                divisor,
  output logic                      done,
  output logic [ssb_pkg::DIV_W-1:0] quotient
);
  import ssb_pkg::*;

  logic [6:0]       rem;
  logic [6:0]       dsr;
  logic [3:0]       cnt;
  logic [7:0]       trial;
  logic             fits;

  // restoring step: bring down the next dividend bit
  assign trial = {rem, quotient[DIV_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= DIV_STEPS;
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 4'd1;
      done <= (cnt == 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (cnt != '0) begin
      rem      <= fits ? 7'(trial - {1'b0, dsr}) : trial[6:0];
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule

### rtl/ssb_datapath.sv
`timescale 1ns / 1ps

module ssb_datapath #(
  parameter int SPRITE_TEXELS = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  ssb_pkg::cmd_t       cmd,
  output ssb_pkg::stat_t      stat,
  // configuration writes
  input  logic                cfg_wr,
  input  logic [2:0]          cfg_index,
  input  logic [12:0]         cfg_data,
  // input item fields
  input  logic [11:0]         texel_index,
  input  logic [31:0]         texel_value,
  input  logic [7:0]          tile_x,
  input  logic [7:0]          tile_y,
  input  logic [7:0]          camera_x,
  input  logic [7:0]          camera_y,
  input  logic [5:0]          pixel_col,
  input  logic [5:0]          pixel_row,
  input  logic                first_of_tile,
  // result register
  output logic                out_valid,
  input  logic                out_ready,
  output logic [23:0]         frame_address,
  output logic [30:0]         pixel_value
);
  import ssb_pkg::*;

  localparam int AW = (SPRITE_TEXELS > 1) ? $clog2(SPRITE_TEXELS) : 1;

  logic [6:0]  sprite_width, sprite_height, tile_width, tile_height;
  logic [12:0] screen_width, screen_height;
  logic [12:0] sw_clip, sh_clip;

  logic [7:0]  f_tx, f_ty, f_cx, f_cy;
  logic [5:0]  f_col, f_row;

  logic [3:0]  bounce_offset;
  logic        bounce_falling;
  logic [3:0]  bounce_step;

  logic signed [17:0] x_calc, y_calc, x_pos, y_pos;
  logic signed [17:0] dx18, dy18;
  logic        on_screen, on_screen_q;

  logic [DIV_W-1:0] div_dividend, div_quotient;
  logic [6:0]  div_divisor;
  logic        div_done;
  logic [6:0]  qy;

  logic [13:0] src;
  logic [16:0] src_ext, tidx_ext;
  logic [23:0] addr_q;
  logic [31:0] texel;

  logic [31:0] sprite_mem [SPRITE_TEXELS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_width  <= RST_SPRITE_W;
      sprite_height <= RST_SPRITE_H;
      tile_width    <= RST_TILE_W;
      tile_height   <= RST_TILE_H;
      screen_width  <= RST_SCREEN_W;
      screen_height <= RST_SCREEN_H;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_SPRITE_W: sprite_width  <= cfg_data[6:0];
        REG_SPRITE_H: sprite_height <= cfg_data[6:0];
        REG_TILE_W:   tile_width    <= cfg_data[6:0];
        REG_TILE_H:   tile_height   <= cfg_data[6:0];
        REG_SCREEN_W: screen_width  <= cfg_data;
        REG_SCREEN_H: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sw_clip = (screen_width  > SCREEN_MAX) ? SCREEN_MAX : screen_width;
  assign sh_clip = (screen_height > SCREEN_MAX) ? SCREEN_MAX : screen_height;

  // draw request fields
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      f_tx  <= tile_x;
      f_ty  <= tile_y;
      f_cx  <= camera_x;
      f_cy  <= camera_y;
      f_col <= pixel_col;
      f_row <= pixel_row;
    end
  end

  // bounce counter, 0 up to 10 and back down
  assign bounce_step = bounce_falling ? bounce_offset - 4'd1 : bounce_offset + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bounce_offset  <= '0;
      bounce_falling <= 1'b0;
    end else if (cmd.latch && first_of_tile) begin
      bounce_offset <= bounce_step;
      if (bounce_step > BOUNCE_TOP) begin
        bounce_falling <= 1'b1;
      end else if (bounce_step == '0) begin
        bounce_falling <= 1'b0;
      end
    end
  end

  assign stat.reject = (tile_width == '0) || (tile_height == '0) ||
                       ({1'b0, f_col} >= tile_width) || ({1'b0, f_row} >= tile_height);

  // destination position, registered every cycle from the held fields
  assign dx18   = 18'(signed'({1'b0, f_tx}) - signed'({1'b0, f_cx}));
  assign dy18   = 18'(signed'({1'b0, f_ty}) - signed'({1'b0, f_cy}));
  assign x_calc = dx18 * signed'({11'd0, tile_width}) + signed'({12'd0, f_col});
  assign y_calc = dy18 * signed'({11'd0, tile_height}) + signed'({12'd0, f_row})
                  - signed'({14'd0, bounce_offset});

  always_ff @(posedge clk) begin
    x_pos <= x_calc;
    y_pos <= y_calc;
  end

  assign on_screen = !x_pos[17] && (x_pos[16:0] < 17'(sw_clip)) &&
                     !y_pos[17] && (y_pos[16:0] < 17'(sh_clip));

  // shared divider for both texel coordinates
  assign div_dividend = cmd.div_sel_x ? DIV_W'(f_col) * DIV_W'(sprite_width)
                                      : DIV_W'(f_row) * DIV_W'(sprite_height);
  assign div_divisor  = cmd.div_sel_x ? tile_width : tile_height;

  ssb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign stat.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.qy_save) begin
      qy <= div_quotient[6:0];
    end
  end

  // texel index and frame address
  always_ff @(posedge clk) begin
    if (cmd.idx_en) begin
      src         <= 14'(qy) * 14'(sprite_width) + 14'(div_quotient[6:0]);
      addr_q      <= 24'(25'(y_pos[11:0]) * 25'(sw_clip) + 25'(x_pos[11:0]));
      on_screen_q <= on_screen;
    end
  end

  assign src_ext     = {3'd0, src};
  assign tidx_ext    = {5'd0, texel_index};
  assign stat.src_ok = 32'(src) < 32'(SPRITE_TEXELS);

  // sprite store
  always_ff @(posedge clk) begin
    if (cmd.load_wr && (32'(texel_index) < 32'(SPRITE_TEXELS))) begin
      sprite_mem[tidx_ext[AW-1:0]] <= texel_value;
    end
    if (cmd.rd_en) begin
      texel <= sprite_mem[src_ext[AW-1:0]];
    end
  end

  assign stat.keep     = !texel[31] && on_screen_q;
  assign stat.out_free = !out_valid || out_ready;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      frame_address <= addr_q;
      pixel_value   <= texel[30:0];
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_bounce_range: assert property (@(posedge clk) disable iff (rst)
    bounce_offset <= BOUNCE_PEAK)
    else $error("bounce offset out of range");

  a_bounce_peak: assert property (@(posedge clk) disable iff (rst)
    (bounce_offset == BOUNCE_PEAK) |-> bounce_falling)
    else $error("bounce not falling at peak");

endmodule

### rtl/ssb_ctrl.sv
`timescale 1ns / 1ps

module ssb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_kind,
  output logic           in_ready,
  input  ssb_pkg::stat_t stat,
  output ssb_pkg::cmd_t  cmd
);
  import ssb_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_kind == KIND_DRAW) state_next = S_PREP;
      end
      S_PREP:  state_next = stat.reject ? S_IDLE : S_DIV_Y;
      S_DIV_Y: begin
        if (stat.div_done) state_next = S_DIV_X;
      end
      S_DIV_X: begin
        if (stat.div_done) state_next = S_INDEX;
      end
      S_INDEX: state_next = S_READ;
      S_READ:  state_next = stat.src_ok ? S_CHECK : S_IDLE;
      S_CHECK: state_next = stat.keep ? S_OUT : S_IDLE;
      S_OUT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_wr = in_valid && (in_kind == KIND_LOAD);
        cmd.latch   = in_valid && (in_kind == KIND_DRAW);
      end
      S_PREP: begin
        cmd.div_start = !stat.reject;
      end
      S_DIV_Y: begin
        cmd.qy_save   = stat.div_done;
        cmd.div_start = stat.div_done;
        cmd.div_sel_x = 1'b1;
      end
      S_DIV_X: cmd.div_sel_x = 1'b1;
      S_INDEX: cmd.idx_en    = 1'b1;
      S_READ:  cmd.rd_en     = 1'b1;
      S_CHECK: ;
      S_OUT:   cmd.out_load  = stat.out_free;
      default: ;
    endcase
  end

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_Y && !stat.div_done) |=> (state == S_DIV_Y))
    else $error("left divide before quotient ready");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !stat.out_free) |=> (state == S_OUT))
    else $error("result dropped while output busy");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (!cmd.load_wr && !cmd.latch))
    else $error("request taken while busy");

endmodule

### rtl/scaled_sprite_blit_bounce.sv
`timescale 1ns / 1ps

// sprite blitter with nearest-neighbor scaling, color key and bounce offset
//
// s_* channel: one request per beat, s_tuser selects the kind
//   load request: writes texel_value into the sprite store at texel_index
//   when that index is inside the store; s_tready stays high
//   draw request: names one pixel of a tile; yields at most one write on m_*
// m_* channel: frame buffer writes (address, 31-bit color) from a result
//   register, so a new request is taken while a result still waits
// cfg_*: register writes, always ready; only write while the block is idle
//
// a draw that yields a write shows it on m_tvalid with s_tready back high in
// that same cycle; s_tready stays low while a draw is in progress; each of
// the two divides runs on the shared restoring divider (13 quotient bits, one
// per cycle, done flag raised with the last bit); with no write, s_tready
// returns after S_PREP for a pixel outside the tile, S_READ for a texel index
// past the store, S_CHECK for a transparent or off-screen pixel
// a stalled m_tready holds a finished draw in its final state and keeps
// s_tready low until the result register frees up
// reset: registers take their defaults, bounce offset 0 going up; the sprite
// store is not cleared and reads undefined until written

module scaled_sprite_blit_bounce #(
  parameter int SPRITE_TEXELS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // requests
  input  logic        s_tvalid,
  output logic        s_tready,
  // texel_index[11:0], texel_value[43:12], tile_x[51:44], tile_y[59:52],
  // camera_x[67:60], camera_y[75:68], pixel_col[81:76], pixel_row[87:82],
  // first_of_tile[88], zero[95:89]
  input  logic [95:0] s_tdata,
  // kind[0]
  input  logic        s_tuser,
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  // frame_address[23:0], pixel_value[54:24], zero[55]
  output logic [55:0] m_tdata,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import ssb_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  logic [23:0] frame_address;
  logic [30:0] pixel_value;

  assign cfg_ready = 1'b1;

  ssb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ssb_datapath #(
    .SPRITE_TEXELS (SPRITE_TEXELS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_wr        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .texel_index   (s_tdata[11:0]),
    .texel_value   (s_tdata[43:12]),
    .tile_x        (s_tdata[51:44]),
    .tile_y        (s_tdata[59:52]),
    .camera_x      (s_tdata[67:60]),
    .camera_y      (s_tdata[75:68]),
    .pixel_col     (s_tdata[81:76]),
    .pixel_row     (s_tdata[87:82]),
    .first_of_tile (s_tdata[88]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .frame_address (frame_address),
    .pixel_value   (pixel_value)
  );

  assign m_tdata = {1'b0, pixel_value, frame_address};

endmodule
